// File: rtl/core/lcgs_pkg.sv
// Shared constants and handshake structs for the combined LCG shuffle generator.
// Used by lcgs_mulmod, lcgs_slot_div and combined_lcg_shuffle_uniform_top.
package lcgs_pkg;

  // Default shuffle table depth
  localparam int TableDepthDef = 32;
  // Extra warm-up steps of the first generator on reseed
  localparam int WarmupSteps   = 8;

  // Generator word width and multiplier widths
  localparam int GenW  = 31;
  localparam int MulW  = 16;
  localparam int FoldW = 8;
  localparam int ProdW = GenW + MulW;
  localparam int SumW  = 32;

  // First generator: modulus 2^31 - 85
  localparam logic [SumW-1:0]  ModA  = 32'd2147483563;
  localparam logic [MulW-1:0]  MulA  = 16'd40014;
  localparam logic [FoldW-1:0] FoldA = 8'd85;
  // Second generator: modulus 2^31 - 249
  localparam logic [SumW-1:0]  ModB  = 32'd2147483399;
  localparam logic [MulW-1:0]  MulB  = 16'd40692;
  localparam logic [FoldW-1:0] FoldB = 8'd249;

  // Largest output value
  localparam logic [GenW-1:0] OutTop = 31'd2147483562;

  // Operation codes of the input word
  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_e;

  // Request into the shared modular multiplier
  typedef struct packed {
    logic start;
    logic sel_b;
  } mm_req_t;

  // Response out of the shared modular multiplier
  typedef struct packed {
    logic done;
    logic sel_b;
  } mm_rsp_t;

endpackage

// File: rtl/core/lcgs_mulmod.sv
// Shared two-stage modular multiplier: z * mul mod (2^31 - c) for either generator.
// Depends on lcgs_pkg for constants and the request/response structs.
module lcgs_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lcgs_pkg::mm_req_t         req_i,
  input  logic [lcgs_pkg::GenW-1:0] operand_i,
  output lcgs_pkg::mm_rsp_t         rsp_o,
  output logic [lcgs_pkg::GenW-1:0] result_o
);

  logic                       v1_q, v2_q;
  logic                       sel1_q, sel2_q;
  logic [lcgs_pkg::ProdW-1:0] prod_q, prod_d;
  logic [lcgs_pkg::SumW-1:0]  sum_q, sum_d;
  logic [lcgs_pkg::MulW-1:0]  mul;
  logic [lcgs_pkg::FoldW-1:0] fold;
  logic [lcgs_pkg::SumW-1:0]  modulus;
  logic [lcgs_pkg::SumW-1:0]  reduced;

  // Stage one: full product with the generator's multiplier
  assign mul    = req_i.sel_b ? lcgs_pkg::MulB : lcgs_pkg::MulA;
  assign prod_d = lcgs_pkg::ProdW'(operand_i) * lcgs_pkg::ProdW'(mul);

  // Stage two: fold the bits above 2^31 back in, since 2^31 == c mod M
  assign fold  = sel1_q ? lcgs_pkg::FoldB : lcgs_pkg::FoldA;
  assign sum_d = lcgs_pkg::SumW'(prod_q[lcgs_pkg::ProdW-1:lcgs_pkg::GenW])
               * lcgs_pkg::SumW'(fold)
               + lcgs_pkg::SumW'(prod_q[lcgs_pkg::GenW-1:0]);

  // Output: one compare and subtract, the folded sum stays below 2M
  assign modulus  = sel2_q ? lcgs_pkg::ModB : lcgs_pkg::ModA;
  assign reduced  = (sum_q >= modulus) ? (sum_q - modulus) : sum_q;
  assign result_o = reduced[lcgs_pkg::GenW-1:0];

  assign rsp_o.done  = v2_q;
  assign rsp_o.sel_b = sel2_q;

  // Advance the stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  // Hold the stage data
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sel1_q <= req_i.sel_b;
    sum_q  <= sum_d;
    sel2_q <= sel1_q;
  end

endmodule

// File: rtl/core/lcgs_slot_div.sv
// Reciprocal-multiply divider that maps the last output to a shuffle table slot.
// Depends on lcgs_pkg for the output range and generator width.
module lcgs_slot_div #(
  parameter int TABLE_DEPTH = lcgs_pkg::TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lcgs_pkg::GenW-1:0]      value_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_o
);

  localparam int SlotW = $clog2(TABLE_DEPTH);
  localparam int GenW  = lcgs_pkg::GenW;
  localparam int QuoW  = SlotW + 1;
  localparam int ProdW = GenW + QuoW;
  localparam int RemW  = GenW + 1;
  localparam longint unsigned SlotDiv =
    64'(lcgs_pkg::OutTop) / 64'(TABLE_DEPTH) + 64'd1;
  // floor(2^31 / divisor); the product estimate is then low by at most one
  localparam longint unsigned Recip = (64'd1 << GenW) / SlotDiv;

  logic             busy_q;
  logic [GenW-1:0]  val_q;
  logic [QuoW-1:0]  est_q;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [ProdW-1:0] prod;
  logic [RemW-1:0]  rem;

  // Estimate the quotient from the reciprocal
  assign prod = ProdW'(value_i) * ProdW'(Recip);

  // Correct the estimate with one compare against the divisor
  assign rem   = {1'b0, val_q} - RemW'(est_q) * RemW'(SlotDiv);
  assign quo_d = (rem >= RemW'(SlotDiv)) ? (est_q + QuoW'(1)) : est_q;

  assign done_o = !busy_q;

  // Saturate to the last slot
  assign slot_o = (quo_q >= QuoW'(TABLE_DEPTH))
                ? SlotW'(TABLE_DEPTH - 1) : quo_q[SlotW-1:0];

  // Mark the correction cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  // Hold the operand and estimate, then the corrected quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      est_q <= prod[ProdW-1:GenW];
    end
    if (busy_q) begin
      quo_q <= quo_d;
    end
  end

endmodule

// File: rtl/core/combined_lcg_shuffle_uniform_top.sv
// Top level of the combined LCG uniform generator with a shuffle table.
// Depends on lcgs_pkg, lcgs_mulmod and lcgs_slot_div.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | operation_i, seed_value_i
//   out     | output    | out_valid_o/out_stall_i | uniform_value_o
//
// A reseed word runs TABLE_DEPTH+8 steps of the first generator after accept;
// every step is one issue plus two stages of the shared modular multiplier.
// A draw word runs accept, two issues into the multiplier, waits for both
// results, the table read and the output write once the output register is
// free; the slot is registered by the divider well before the table read.
// Reset sets both generators to one; the table is undefined until a reseed.
// The input is stalled while a word is at work; a finished word waits in the
// output register and the next input word is taken meanwhile.
module combined_lcg_shuffle_uniform_top #(
  parameter int TABLE_DEPTH = lcgs_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [lcgs_pkg::GenW-1:0] seed_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lcgs_pkg::GenW-1:0] uniform_value_o
);

  localparam int SlotW = $clog2(TABLE_DEPTH);
  localparam int Steps = TABLE_DEPTH + lcgs_pkg::WarmupSteps;
  localparam int CntW  = $clog2(Steps + 1);
  localparam int GenW  = lcgs_pkg::GenW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RS_ISSUE,
    ST_RS_WAIT,
    ST_DR_A,
    ST_DR_B,
    ST_DR_WAIT,
    ST_DR_READ,
    ST_DR_CALC
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    cnt_dec;
  logic [GenW-1:0]    gen_a_q, gen_b_q;
  logic [GenW-1:0]    last_q;
  logic               out_valid_q;
  logic [GenW-1:0]    out_data_q;
  logic [GenW-1:0]    seed_clamped;
  logic               accept;
  logic               out_free;

  lcgs_pkg::mm_req_t  mm_req;
  lcgs_pkg::mm_rsp_t  mm_rsp;
  logic [GenW-1:0]    mm_operand;
  logic [GenW-1:0]    mm_result;

  logic               div_start;
  logic               div_done;
  logic [SlotW-1:0]   slot;

  logic [GenW-1:0]    table_mem [TABLE_DEPTH];
  logic [GenW-1:0]    rd_q;
  logic               mem_we;
  logic [SlotW-1:0]   mem_waddr;
  logic [GenW-1:0]    mem_wdata;
  logic               mem_re;

  logic [GenW:0]      diff;
  logic [GenW:0]      wrapped;
  logic [GenW-1:0]    draw_value;

  // Handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign uniform_value_o = out_data_q;

  assign seed_clamped = (seed_value_i == '0) ? GenW'(1) : seed_value_i;
  assign cnt_dec      = cnt_q - CntW'(1);

  // Drive the shared multiplier
  assign mm_req.start = (state_q == ST_RS_ISSUE) || (state_q == ST_DR_A)
                     || (state_q == ST_DR_B);
  assign mm_req.sel_b = (state_q == ST_DR_B);
  assign mm_operand   = (state_q == ST_DR_B) ? gen_b_q : gen_a_q;

  lcgs_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mm_req),
    .operand_i (mm_operand),
    .rsp_o     (mm_rsp),
    .result_o  (mm_result)
  );

  // Start the slot divider with every draw word
  assign div_start = accept && (operation_i == lcgs_pkg::OP_DRAW);

  lcgs_slot_div #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_slot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (last_q),
    .done_o  (div_done),
    .slot_o  (slot)
  );

  // Form the draw: table entry minus second generator, wrapped into range
  assign diff       = {1'b0, rd_q} - {1'b0, gen_b_q};
  assign wrapped    = (diff[GenW] || (diff == '0))
                    ? (diff + {1'b0, lcgs_pkg::OutTop}) : diff;
  assign draw_value = wrapped[GenW-1:0];

  // Select table writes and reads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = gen_a_q;
    mem_re    = 1'b0;
    case (state_q)
      ST_RS_WAIT: begin
        mem_we    = mm_rsp.done && (cnt_q <= CntW'(TABLE_DEPTH));
        mem_waddr = cnt_dec[SlotW-1:0];
        mem_wdata = mm_result;
      end
      ST_DR_READ: begin
        mem_re = div_done;
      end
      ST_DR_CALC: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Write and read the shuffle table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= table_mem[slot];
    end
  end

  // Sequence reseed and draw words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      gen_a_q     <= GenW'(1);
      gen_b_q     <= GenW'(1);
      last_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Drop the output word once taken
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (operation_i == lcgs_pkg::OP_RESEED) begin
              gen_a_q <= seed_clamped;
              gen_b_q <= seed_clamped;
              cnt_q   <= CntW'(Steps);
              state_q <= ST_RS_ISSUE;
            end else begin
              state_q <= ST_DR_A;
            end
          end
        end
        ST_RS_ISSUE: begin
          state_q <= ST_RS_WAIT;
        end
        ST_RS_WAIT: begin
          if (mm_rsp.done) begin
            gen_a_q <= mm_result;
            cnt_q   <= cnt_dec;
            if (cnt_q == CntW'(1)) begin
              last_q  <= mm_result;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_RS_ISSUE;
            end
          end
        end
        ST_DR_A: begin
          state_q <= ST_DR_B;
        end
        ST_DR_B: begin
          state_q <= ST_DR_WAIT;
        end
        ST_DR_WAIT: begin
          if (mm_rsp.done) begin
            if (mm_rsp.sel_b) begin
              gen_b_q <= mm_result;
              state_q <= ST_DR_READ;
            end else begin
              gen_a_q <= mm_result;
            end
          end
        end
        ST_DR_READ: begin
          if (div_done) begin
            state_q <= ST_DR_CALC;
          end
        end
        ST_DR_CALC: begin
          // Hold until the output register is free
          if (out_free) begin
            last_q      <= draw_value;
            out_data_q  <= draw_value;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for combined_lcg_shuffle_uniform_top.
// Depends on lcgs_pkg and the RTL under rtl/core; holds its own generator model.
// Directed reseed/draw words first, then ~700 random words with idling on both sides.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = lcgs_pkg::TableDepthDef;
  localparam int GenW  = lcgs_pkg::GenW;

  // Model of both Lehmer streams and the shuffle table
  class shuffle_gen_model;
    localparam longint unsigned ModFirst  = 64'd2147483563;
    localparam longint unsigned MulFirst  = 64'd40014;
    localparam longint unsigned ModSecond = 64'd2147483399;
    localparam longint unsigned MulSecond = 64'd40692;
    localparam longint unsigned TopValue  = 64'd2147483562;
    localparam longint unsigned SlotDiv   = 64'd1 + TopValue / Depth;

    bit [30:0] gen_first;
    bit [30:0] gen_second;
    bit [30:0] prev_value;
    bit [30:0] slots[Depth];
    bit [30:0] pending_values[$];
    int        mismatches;

    function new();
      gen_first  = 31'd1;
      gen_second = 31'd1;
      prev_value = '0;
      foreach (slots[i]) slots[i] = '0;
      mismatches = 0;
    endfunction

    // Advance the state by one accepted word and queue any value it yields
    function void take_word(lcgs_pkg::op_e op, bit [30:0] seed);
      longint unsigned acc;
      longint unsigned slot;
      longint          diff;
      if (op == lcgs_pkg::OP_RESEED) begin
        acc = (seed == 0) ? 64'd1 : 64'(seed);
        gen_second = acc[30:0];
        for (int n = Depth + 8; n >= 1; n--) begin
          acc = (acc * MulFirst) % ModFirst;
          if (n <= Depth) slots[n-1] = acc[30:0];
        end
        gen_first  = acc[30:0];
        prev_value = slots[0];
      end else begin
        acc = (64'(gen_first) * MulFirst) % ModFirst;
        gen_first = acc[30:0];
        acc = (64'(gen_second) * MulSecond) % ModSecond;
        gen_second = acc[30:0];
        slot = 64'(prev_value) / SlotDiv;
        if (slot >= Depth) slot = Depth - 1;
        diff = longint'(slots[slot]) - longint'(gen_second);
        slots[slot] = gen_first;
        if (diff < 1) diff += longint'(TopValue);
        prev_value = diff[30:0];
        pending_values.push_back(prev_value);
      end
    endfunction

    // Compare one delivered word with the oldest pending value
    function void match_value(bit [30:0] got);
      bit [30:0] want;
      if (pending_values.size() == 0) begin
        $error("uniform_value: unexpected word, actual %0d", got);
        mismatches++;
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
        $error("uniform_value: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  lcgs_pkg::op_e       operation_i;
  logic [GenW-1:0]     seed_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [GenW-1:0]     uniform_value_o;

  shuffle_gen_model model;
  int  results_seen = 0;
  bit  quiet = 1'b0;
  bit  long_hold_done = 1'b0;

  combined_lcg_shuffle_uniform_top #(
    .TABLE_DEPTH(Depth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .seed_value_i   (seed_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .uniform_value_o(uniform_value_o)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every word taken from the output
  always @(posedge clk) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      model.match_value(uniform_value_o);
      results_seen++;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 60) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall_i <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted; optionally idle first
  task automatic send_word(input lcgs_pkg::op_e op, input logic [GenW-1:0] seed,
                           input bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    seed_value_i <= seed;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    model.take_word(op, seed);
    @(negedge clk);
  endtask

  // Reseed with the given seed, then the given number of draws with alternating all-ones and zero seed fields
  task automatic reseed_and_draw(input logic [GenW-1:0] seed, input int draws);
    send_word(lcgs_pkg::OP_RESEED, seed, 1'b1);
    for (int i = 0; i < draws; i++)
      send_word(lcgs_pkg::OP_DRAW, (i % 2 == 0) ? 31'h7FFF_FFFF : 31'h0, 1'b1);
  endtask

  initial begin
    int              total;
    logic [GenW-1:0] seed;
    model        = new();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= lcgs_pkg::OP_DRAW;
    seed_value_i <= '0;
    total        = 700;
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed: zero seed, one, all ones, both moduli, top output value
    reseed_and_draw(31'd0, 3);
    reseed_and_draw(31'd1, 2);
    reseed_and_draw(31'h7FFF_FFFF, 3);
    reseed_and_draw(31'd2147483563, 3);
    reseed_and_draw(31'd2147483399, 2);
    reseed_and_draw(31'd2147483562, 2);
    reseed_and_draw(31'd12345, 2);

    // Random: mostly draws, occasional reseeds with varied seeds
    for (int i = 0; i < total; i++) begin
      if (i == total - 100) quiet = 1'b1;
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 5))
          0:       seed = GenW'($urandom_range(0, 3));
          1:       seed = GenW'(32'd2147483563 + $urandom_range(0, 84) - 32'd3);
          2:       seed = GenW'(32'd2147483399 + $urandom_range(0, 6) - 32'd3);
          3:       seed = GenW'(32'h7FFF_FFFF - $urandom_range(0, 3));
          default: seed = GenW'($urandom());
        endcase
        send_word(lcgs_pkg::OP_RESEED, seed, 1'b1);
      end else begin
        seed = GenW'($urandom());
        send_word(lcgs_pkg::OP_DRAW, seed, 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every pending value, then for the block to settle
    while (model.pending_values.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (model.mismatches == 0 && model.pending_values.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lcgs_pkg.sv
rtl/core/lcgs_mulmod.sv
rtl/core/lcgs_slot_div.sv
rtl/core/combined_lcg_shuffle_uniform_top.sv
test/tb_top.sv
